// File: rtl/ils_pkg.sv
// ils_pkg: shared types and constants for the indexed list store
// operation and status codes, cell actions and the shift command struct
// no dependencies
package ils_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned PosW     = 8;
  localparam int unsigned ValW     = 32;
  localparam int unsigned OpW      = 3;
  localparam int unsigned StW      = 2;

  // value returned when nothing is read
  localparam logic [ValW-1:0] NoneValue = '1;

  typedef enum logic [OpW-1:0] {
    OP_READ   = 3'd0,
    OP_FRONT  = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic            ins_en;  // open a gap at pos and load value there
    logic            del_en;  // close the gap at pos
    logic [PosW-1:0] pos;     // effective position of the change
    logic [ValW-1:0] value;   // value to load on insert
  } shift_cmd_t;

endpackage

// File: rtl/indexed_list_store.sv
// indexed_list_store: top level of the positional list store
// a chain of ils_cell slots driven by ils_ctrl; uses ils_pkg
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+-----------------------------------
//   command | in        | start_i, busy_o    | operation_i, position_i, value_i
//   result  | out       | done_o (strobe)    | read_value_o, status_o
//
// One item per cycle: every slot shifts, loads or holds at once on the edge that
// accepts the item, so busy_o stays low. The result is on the ports in the cycle
// after acceptance, marked by done_o, taken from a single output register.
// The read path is a DEPTH-to-one select over the slot outputs.
// Reset empties the list (length zero); slot contents are undefined until written.
// The receiver cannot stall; results are never held.
module indexed_list_store #(
  parameter int unsigned DEPTH = ils_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ils_pkg::OpW-1:0]       operation_i,
  input  logic [ils_pkg::PosW-1:0]      position_i,
  input  logic signed [ils_pkg::ValW-1:0] value_i,
  output logic                          done_o,
  output logic signed [ils_pkg::ValW-1:0] read_value_o,
  output logic [ils_pkg::StW-1:0]       status_o
);

  logic                     accept;
  ils_pkg::shift_cmd_t      cmd;
  logic                     rd_ok;
  ils_pkg::status_e         status;
  logic [ils_pkg::ValW-1:0] slot [DEPTH];
  logic [ils_pkg::ValW-1:0] rd_value;
  logic                     done_d, done_q;
  logic [ils_pkg::ValW-1:0] read_value_d, read_value_q;
  logic [ils_pkg::StW-1:0]  status_d, status_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // decode and length
  ils_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .operation_i(operation_i),
    .position_i (position_i),
    .value_i    (value_i),
    .cmd_o      (cmd),
    .rd_ok_o    (rd_ok),
    .status_o   (status)
  );

  // chain of slots, each fed by its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ils_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (slot[(g == 0) ? 0 : g - 1]),
      .right_i(slot[(g == DEPTH - 1) ? g : g + 1]),
      .value_o(slot[g])
    );
  end

  // select the slot at the read position
  always_comb begin
    rd_value = ils_pkg::NoneValue;
    for (int i = 0; i < DEPTH; i++) begin
      if (position_i == ils_pkg::PosW'(i)) begin
        rd_value = slot[i];
      end
    end
  end

  // result register
  assign done_d       = accept;
  assign read_value_d = rd_ok ? rd_value : ils_pkg::NoneValue;
  assign status_d     = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  // every accepted item gives exactly one result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept))
    else $error("result strobe does not follow item");
  // a failed item reports no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ils_pkg::ST_DONE) |-> read_value_o == ils_pkg::NoneValue)
    else $error("value returned on failed item");
  // insert and delete never fire together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ins_en && cmd.del_en))
    else $error("insert and delete at once");
`endif

endmodule

// File: rtl/ils_cell.sv
// ils_cell: one slot of the list, holds a single value
// shifts with its neighbors on insert and delete; uses ils_pkg
// no submodules
module ils_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  ils_pkg::shift_cmd_t           cmd_i,
  input  logic [ils_pkg::ValW-1:0]      left_i,
  input  logic [ils_pkg::ValW-1:0]      right_i,
  output logic [ils_pkg::ValW-1:0]      value_o
);

  localparam logic [ils_pkg::PosW-1:0] Idx = IDX[ils_pkg::PosW-1:0];

  logic [ils_pkg::ValW-1:0] value_d, value_q;

  // pick the next slot content from the broadcast command
  always_comb begin
    value_d = value_q;
    if (cmd_i.ins_en) begin
      if (Idx == cmd_i.pos) begin
        value_d = cmd_i.value;
      end else if (Idx > cmd_i.pos) begin
        value_d = left_i;
      end
    end else if (cmd_i.del_en) begin
      if (Idx >= cmd_i.pos) begin
        value_d = right_i;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// File: rtl/ils_ctrl.sv
// ils_ctrl: length counter and operation decode for the list store
// produces the shift command for the cells and the status of each item
// uses ils_pkg
module ils_ctrl #(
  parameter int unsigned DEPTH = ils_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ils_pkg::OpW-1:0]       operation_i,
  input  logic [ils_pkg::PosW-1:0]      position_i,
  input  logic [ils_pkg::ValW-1:0]      value_i,
  output ils_pkg::shift_cmd_t           cmd_o,
  output logic                          rd_ok_o,
  output ils_pkg::status_e              status_o
);

  localparam int unsigned LenW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = ils_pkg::PosW + 1;
  localparam logic [LenW-1:0] Full = LenW'(DEPTH);

  logic [LenW-1:0]         len_d, len_q;
  logic [CmpW-1:0]         len_ext, pos_ext, ins_ext;
  logic [ils_pkg::PosW-1:0] ins_pos;
  logic                    is_ins, ins_ok, del_ok, full;
  ils_pkg::op_e            op;

  assign op      = ils_pkg::op_e'(operation_i);
  assign len_ext = CmpW'(len_q);
  assign pos_ext = CmpW'(position_i);
  assign full    = (len_q == Full);

  // effective insert position per operation
  always_comb begin
    ins_pos = position_i;
    is_ins  = 1'b0;
    case (op)
      ils_pkg::OP_FRONT: begin
        ins_pos = '0;
        is_ins  = 1'b1;
      end
      ils_pkg::OP_APPEND: begin
        ins_pos = ils_pkg::PosW'(len_q);
        is_ins  = 1'b1;
      end
      ils_pkg::OP_INSERT: begin
        is_ins  = 1'b1;
      end
      default: begin
        is_ins  = 1'b0;
      end
    endcase
  end

  assign ins_ext = CmpW'(ins_pos);
  assign ins_ok  = is_ins && (ins_ext <= len_ext) && !full;
  assign del_ok  = (op == ils_pkg::OP_DELETE) && (pos_ext < len_ext);
  assign rd_ok_o = (op == ils_pkg::OP_READ) && (pos_ext < len_ext);

  // status of the item, range check before full check
  always_comb begin
    status_o = ils_pkg::ST_RANGE;
    if (is_ins) begin
      if (ins_ext > len_ext) begin
        status_o = ils_pkg::ST_RANGE;
      end else if (full) begin
        status_o = ils_pkg::ST_FULL;
      end else begin
        status_o = ils_pkg::ST_DONE;
      end
    end else if (rd_ok_o || del_ok) begin
      status_o = ils_pkg::ST_DONE;
    end
  end

  // command to the chain, only on an accepted item
  always_comb begin
    cmd_o.ins_en = accept_i && ins_ok;
    cmd_o.del_en = accept_i && del_ok;
    cmd_o.pos    = is_ins ? ins_pos : position_i;
    cmd_o.value  = value_i;
  end

  // length counter
  always_comb begin
    len_d = len_q;
    if (cmd_o.ins_en) begin
      len_d = len_q + LenW'(1);
    end else if (cmd_o.del_en) begin
      len_d = len_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

`ifndef SYNTHESIS
  // length stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= Full)
    else $error("length beyond depth");
  // a successful insert grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins_en |=> len_q == $past(len_q) + LenW'(1))
    else $error("insert did not grow length");
  // a successful delete shrinks the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.del_en |=> len_q == $past(len_q) - LenW'(1))
    else $error("delete did not shrink length");
  // full status only when the store is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o == ils_pkg::ST_FULL) |-> full)
    else $error("full status with room left");
`endif

endmodule

// File: tb/indexed_list_store_checker.sv
// indexed_list_store_checker: predicts every result of the list store and compares
// keeps its own copy of the sequence and a queue of expected results; uses ils_pkg
module indexed_list_store_checker #(
  parameter int unsigned DEPTH = ils_pkg::DefDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [ils_pkg::OpW-1:0]         operation_i,
  input  logic [ils_pkg::PosW-1:0]        position_i,
  input  logic signed [ils_pkg::ValW-1:0] value_i,
  input  logic                            done_i,
  input  logic signed [ils_pkg::ValW-1:0] read_value_i,
  input  logic [ils_pkg::StW-1:0]         status_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     outstanding_o
);
  import ils_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [ValW-1:0] read_value;
    status_e         status;
  } list_result_t;

  // shadow copy of the sequence
  logic [ValW-1:0] seq_entries [DEPTH];
  int unsigned     seq_len;

  list_result_t    expected_results [$];
  int unsigned     result_idx;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    result_idx    = 0;
    seq_len       = 0;
  end

  // open a slot at the given position and load the value there
  function automatic status_e place_value(int unsigned at, logic [ValW-1:0] val);
    int unsigned i;
    if (at > seq_len) return ST_RANGE;
    if (seq_len >= DEPTH) return ST_FULL;
    for (i = seq_len; i > at; i--) seq_entries[i] = seq_entries[i-1];
    seq_entries[at] = val;
    seq_len++;
    return ST_DONE;
  endfunction

  // apply one item to the shadow sequence and return what the block should answer
  function automatic list_result_t apply_item(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                                              logic [ValW-1:0] val);
    list_result_t res;
    int unsigned  i;
    res.read_value = NoneValue;
    res.status     = ST_RANGE;
    case (op)
      OP_READ: begin
        if (pos < seq_len) begin
          res.read_value = seq_entries[pos];
          res.status     = ST_DONE;
        end
      end
      OP_FRONT:  res.status = place_value(0, val);
      OP_APPEND: res.status = place_value(seq_len, val);
      OP_INSERT: res.status = place_value(pos, val);
      OP_DELETE: begin
        if (pos < seq_len) begin
          for (i = pos; i + 1 < seq_len; i++) seq_entries[i] = seq_entries[i+1];
          seq_len--;
          res.status = ST_DONE;
        end
      end
      default: res.status = ST_RANGE;
    endcase
    return res;
  endfunction

  function automatic void note_failure(string what, logic [ValW-1:0] want,
                                       logic [ValW-1:0] got);
    if (fail_count_o < ReportLimit)
      $display("result %0d: %s expected %h got %h", result_idx, what, want, got);
    fail_count_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      seq_len = 0;
      expected_results.delete();
      outstanding_o = 0;
    end else begin
      // the strobed result belongs to the oldest item still waiting
      if (done_i === 1'b1) begin
        if (expected_results.size() == 0) begin
          note_failure("unexpected result, status", '0, 32'(status_i));
        end else begin
          want = expected_results.pop_front();
          if (read_value_i !== want.read_value)
            note_failure("read_value", want.read_value, read_value_i);
          if (status_i !== want.status)
            note_failure("status", 32'(want.status), 32'(status_i));
        end
        result_idx++;
      end
      // accepted item: predict its result
      if (start_i === 1'b1 && busy_i === 1'b0)
        expected_results.push_back(apply_item(operation_i, position_i, value_i));
      outstanding_o = expected_results.size();
    end
  end

endmodule

// File: tb/indexed_list_store_tb.sv
// indexed_list_store_tb: stimulus and verdict for the indexed list store
// drives directed and random items; checking is done by indexed_list_store_checker
module indexed_list_store_tb;
  import ils_pkg::*;

  localparam int unsigned ListDepth   = DefDepth;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseCount  = 12;
  localparam int unsigned PhaseItems  = 75;
  localparam int unsigned QuietPhases = 2;

  // operation codes the block does not define
  localparam logic [OpW-1:0] OpFirstUnused = 3'(OP_DELETE + 1);
  localparam logic [OpW-1:0] OpLastUnused  = '1;

  // random phase flavors
  localparam int unsigned PhGrow   = 0;
  localparam int unsigned PhShrink = 1;
  localparam int unsigned PhMixed  = 2;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [OpW-1:0]         operation;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] value;
  logic                   done;
  logic signed [ValW-1:0] read_value;
  logic [StW-1:0]         status;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycles;
  int unsigned idle_pct;

  indexed_list_store #(.DEPTH(ListDepth)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .operation_i (operation),
    .position_i  (position),
    .value_i     (value),
    .done_o      (done),
    .read_value_o(read_value),
    .status_o    (status)
  );

  indexed_list_store_checker #(.DEPTH(ListDepth)) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .operation_i  (operation),
    .position_i   (position),
    .value_i      (value),
    .done_i       (done),
    .read_value_i (read_value),
    .status_i     (status),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one item, with an optional idle burst ahead of it, and wait for acceptance
  task automatic send_item(logic [OpW-1:0] op, logic [PosW-1:0] pos, logic [ValW-1:0] val);
    int unsigned gap;
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // operation mix per phase flavor
  function automatic logic [OpW-1:0] random_op(int unsigned flavor);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (flavor)
      PhGrow: begin
        if (roll < 35) return OP_INSERT;
        if (roll < 55) return OP_APPEND;
        if (roll < 70) return OP_FRONT;
        if (roll < 85) return OP_READ;
        if (roll < 95) return OP_DELETE;
      end
      PhShrink: begin
        if (roll < 55) return OP_DELETE;
        if (roll < 80) return OP_READ;
        if (roll < 88) return OP_INSERT;
        if (roll < 93) return OP_APPEND;
        if (roll < 97) return OP_FRONT;
      end
      default: begin
        if (roll < 25) return OP_READ;
        if (roll < 45) return OP_INSERT;
        if (roll < 70) return OP_DELETE;
        if (roll < 82) return OP_APPEND;
        if (roll < 94) return OP_FRONT;
      end
    endcase
    return OpLastUnused - 3'($urandom_range(0, OpLastUnused - OpFirstUnused));
  endfunction

  function automatic logic [PosW-1:0] random_pos();
    if ($urandom_range(0, 99) < 85) return PosW'($urandom_range(0, ListDepth + 1));
    return PosW'($urandom_range(0, 255));
  endfunction

  // mostly random words, sometimes the corners
  function automatic logic [ValW-1:0] random_value();
    case ($urandom_range(0, 39))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned i;
    int unsigned phase;
    int unsigned flavor;
    rst_n     = 1'b0;
    start     = 1'b0;
    operation = OP_READ;
    position  = '0;
    value     = '0;
    idle_pct  = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store corners
    send_item(OP_READ,   8'd0,   32'h1234_5678);
    send_item(OP_DELETE, 8'd0,   '0);
    send_item(OP_INSERT, 8'd1,   32'h5555_5555);
    // insert at position equal to length appends
    send_item(OP_INSERT, 8'd0,   32'h8000_0000);
    send_item(OP_APPEND, 8'd255, 32'h7fff_ffff);
    send_item(OP_FRONT,  8'd200, 32'hffff_ffff);
    send_item(OP_READ,   8'd0,   '0);
    send_item(OP_READ,   8'd3,   '0);
    send_item(OP_READ,   8'd255, '0);
    send_item(OpFirstUnused, 8'd0, 32'haaaa_aaaa);
    send_item(OpLastUnused,  8'd1, 32'h5555_5555);
    // fill to capacity
    for (i = 3; i < ListDepth; i++) send_item(OP_APPEND, 8'd0, $urandom);
    // full store: refused inserts, range check before full check
    send_item(OP_FRONT,  8'd0,   32'h0bad_0bad);
    send_item(OP_INSERT, 8'(ListDepth),     32'h0bad_0bad);
    send_item(OP_INSERT, 8'(ListDepth + 1), 32'h0bad_0bad);
    // delete at the head takes only the first value
    send_item(OP_DELETE, 8'd0,   '0);
    send_item(OP_READ,   8'd0,   '0);
    send_item(OP_DELETE, 8'(ListDepth - 2), '0);
    send_item(OP_DELETE, 8'(ListDepth - 2), '0);

    // random phases, quiet at the end
    for (phase = 0; phase < PhaseCount; phase++) begin
      flavor = $urandom_range(PhGrow, PhMixed);
      if (phase >= PhaseCount - QuietPhases || $urandom_range(0, 2) == 0) idle_pct = 0;
      else idle_pct = $urandom_range(10, 40);
      repeat (PhaseItems) send_item(random_op(flavor), random_pos(), random_value());
    end

    // drain
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_ctrl.sv
rtl/indexed_list_store.sv
tb/indexed_list_store_checker.sv
tb/indexed_list_store_tb.sv
